/* rtl/core/fma_pkg.sv */
`timescale 1ns / 1ps

package fma_pkg;

   localparam int RAW_W          = 16;
   localparam int SCALE_W        = 8;
   localparam int FRAME_W        = 18;
   localparam int FRAME_RESET    = 76800;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int DEF_MAX_PIXELS = 131072;
   localparam int DEF_PIXEL_BITS = 16;

   localparam logic [SCALE_W-1:0]    SCALE_MAX         = 8'hFF;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FRAME_PIXELS = 3'd0;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } fma_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } fma_state_type;

endpackage

/* rtl/core/frame_minmax_autoscale.sv */
`timescale 1ns / 1ps

// Min/max contrast stretch of raw PIXEL_BITS-bit frames to 8-bit. A load transaction
// (op 0) writes one pixel into the frame store and updates the running minimum and
// maximum; first=1 restarts the frame. An emit transaction (op 1) reads the next
// stored pixel and returns round((p-min)*255/(max-min+1)), ties to even, with
// frame_end on the last pixel of the frame. A load does not stall the input. An emit
// goes from acceptance to the result register through store read, span/numerator
// prep, the radix-2 divider that yields one quotient bit per cycle, rounding and
// output load when a division is needed, and through store read, prep and output
// load when the result is 0 or 255 by range alone. The input stalls until the emit
// result is loaded. A result waiting in the output register does not stop the next
// load; a later emit holds at its output load until that result is taken. Frame
// size is set by the frame_pixels register (byte address 0), read back through the
// APB port; 0 counts as 1, values above MAX_PIXELS count as MAX_PIXELS. Store entries
// read before any load wrote them give undefined results.

module frame_minmax_autoscale #(
   parameter int MAX_PIXELS = fma_pkg::DEF_MAX_PIXELS,
   parameter int PIXEL_BITS = fma_pkg::DEF_PIXEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [fma_pkg::RAW_W-1:0]         req_pixel,
   input  logic                              req_first,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fma_pkg::SCALE_W-1:0]       rsp_scaled,
   output logic                              rsp_frame_end,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fma_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fma_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fma_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   import fma_pkg::*;

   localparam int POS_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int EFF_W     = $clog2(MAX_PIXELS + 1);
   localparam int CW        = EFF_W + 1;
   localparam int LIM_W     = ((EFF_W > FRAME_W) ? EFF_W : FRAME_W) + 1;
   localparam int EFF_RESET = (FRAME_RESET > MAX_PIXELS) ? MAX_PIXELS : FRAME_RESET;
   localparam int SPAN_W    = PIXEL_BITS + 1;
   localparam int NUM_W     = PIXEL_BITS + SCALE_W;

   function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                input logic [EFF_W-1:0] eff);
      logic [CW-1:0] nxt;
      nxt     = CW'(pos) + CW'(1);
      advance = (nxt >= CW'(eff)) ? '0 : nxt[POS_W-1:0];
   endfunction

   fma_state_type          state_ff, state_in;

   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [EFF_W-1:0]       eff_ff, eff_in;
   logic [POS_W-1:0]       wpos_ff, wpos_in;
   logic [POS_W-1:0]       rpos_ff, rpos_in;
   logic [PIXEL_BITS-1:0]  min_ff, min_in;
   logic [PIXEL_BITS-1:0]  max_ff, max_in;
   logic                   last_ff, last_in;
   logic [PIXEL_BITS-1:0]  diff_ff, diff_in;
   logic [SPAN_W-1:0]      span_ff, span_in;
   logic                   bypass_ff, bypass_in;
   logic [SCALE_W-1:0]     byp_val_ff, byp_val_in;
   logic [SCALE_W-1:0]     res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCALE_W-1:0]     rsp_scaled_ff, rsp_scaled_in;
   logic                   rsp_frame_end_ff, rsp_frame_end_in;

   logic                   csr_wr;
   logic                   csr_hit;
   logic                   req_acc;
   logic                   load_acc;
   logic                   emit_acc;
   logic [PIXEL_BITS-1:0]  pix;
   logic [POS_W-1:0]       base_wpos;
   logic [PIXEL_BITS-1:0]  base_min;
   logic [PIXEL_BITS-1:0]  base_max;
   logic [PIXEL_BITS-1:0]  store_q;
   logic                   empty;
   logic                   below;
   logic                   above;
   logic [NUM_W-1:0]       num;
   logic                   div_start;
   logic                   div_done;
   logic [SCALE_W-1:0]     div_quot;
   logic [SPAN_W-1:0]      div_rem;
   logic [SPAN_W:0]        twice_rem;
   logic                   round_up;
   logic [SCALE_W-1:0]     rounded;
   logic                   out_load;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == ADDR_FRAME_PIXELS[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(frame_ff) : '0;

   always_comb begin
      frame_in = frame_ff;
      eff_in   = eff_ff;
      if (csr_wr) begin
         frame_in = csr_pwdata[FRAME_W-1:0];
         if (csr_pwdata[FRAME_W-1:0] == '0) begin
            eff_in = EFF_W'(1);
         end else if (LIM_W'(csr_pwdata[FRAME_W-1:0]) > LIM_W'(MAX_PIXELS)) begin
            eff_in = EFF_W'(MAX_PIXELS);
         end else begin
            eff_in = EFF_W'(csr_pwdata[FRAME_W-1:0]);
         end
      end
   end

   // transaction intake, load path
   assign req_acc   = req_valid && !req_stall;
   assign load_acc  = req_acc && (req_op == OP_LOAD);
   assign emit_acc  = req_acc && (req_op == OP_EMIT);
   assign pix       = req_pixel[PIXEL_BITS-1:0];
   assign base_wpos = req_first ? '0 : wpos_ff;
   assign base_min  = req_first ? '1 : min_ff;
   assign base_max  = req_first ? '0 : max_ff;

   always_comb begin
      wpos_in = wpos_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      rpos_in = rpos_ff;
      last_in = last_ff;
      if (load_acc) begin
         wpos_in = advance(base_wpos, eff_ff);
         min_in  = (pix < base_min) ? pix : base_min;
         max_in  = (pix > base_max) ? pix : base_max;
      end
      if (emit_acc) begin
         rpos_in = advance(rpos_ff, eff_ff);
         last_in = (CW'(rpos_ff) + CW'(1)) >= CW'(eff_ff);
      end
   end

   fma_store #(
      .DEPTH  (MAX_PIXELS),
      .ADDR_W (POS_W),
      .DATA_W (PIXEL_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_acc),
      .wr_addr (base_wpos),
      .wr_data (pix),
      .rd_addr (rpos_ff),
      .rd_data (store_q)
   );

   // emit datapath
   assign empty = max_ff < min_ff;
   assign below = store_q < min_ff;
   assign above = store_q > max_ff;
   assign num   = {diff_ff, {SCALE_W{1'b0}}} - NUM_W'(diff_ff);

   always_comb begin
      diff_in    = diff_ff;
      span_in    = span_ff;
      bypass_in  = bypass_ff;
      byp_val_in = byp_val_ff;
      if (state_ff == ST_READ) begin
         diff_in    = store_q - min_ff;
         span_in    = {1'b0, max_ff} - {1'b0, min_ff} + SPAN_W'(1);
         bypass_in  = empty || below || above;
         byp_val_in = (!empty && !below && above) ? SCALE_MAX : '0;
      end
   end

   fma_div #(
      .DEN_W (SPAN_W),
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (span_ff),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // round to nearest, ties to even
   assign twice_rem = {div_rem, 1'b0};
   assign round_up  = (twice_rem > {1'b0, span_ff}) ||
                      ((twice_rem == {1'b0, span_ff}) && div_quot[0]);
   assign rounded   = div_quot + SCALE_W'(round_up);

   always_comb begin
      res_in = res_ff;
      if (state_ff == ST_PREP && bypass_ff) begin
         res_in = byp_val_ff;
      end else if (state_ff == ST_DIV && div_done) begin
         res_in = rounded;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (emit_acc) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = bypass_ff ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_PREP: begin
            div_start = !bypass_ff;
         end
         ST_DONE: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_scaled_in    = rsp_scaled_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_scaled_in    = res_ff;
         rsp_frame_end_in = last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scaled    = rsp_scaled_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= FRAME_W'(FRAME_RESET);
         eff_ff       <= EFF_W'(EFF_RESET);
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         eff_ff       <= eff_in;
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff          <= last_in;
      diff_ff          <= diff_in;
      span_ff          <= span_in;
      bypass_ff        <= bypass_in;
      byp_val_ff       <= byp_val_in;
      res_ff           <= res_in;
      rsp_scaled_ff    <= rsp_scaled_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   a_emit_to_read: assert property (@(posedge clock) disable iff (reset)
      emit_acc |=> state_ff == ST_READ)
      else $error("emit transaction did not start a store read");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_quot_below_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |-> div_quot != SCALE_MAX)
      else $error("unrounded quotient reached full scale");

   a_range_ordered: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> min_ff <= max_ff)
      else $error("minimum above maximum after a load");

endmodule

/* rtl/core/fma_store.sv */
`timescale 1ns / 1ps

module fma_store #(
   parameter int DEPTH  = fma_pkg::DEF_MAX_PIXELS,
   parameter int ADDR_W = 17,
   parameter int DATA_W = fma_pkg::DEF_PIXEL_BITS
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fma_div.sv */
`timescale 1ns / 1ps

module fma_div #(
   parameter int DEN_W = fma_pkg::DEF_PIXEL_BITS + 1,
   parameter int NUM_W = fma_pkg::DEF_PIXEL_BITS + fma_pkg::SCALE_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              num,
   input  logic [DEN_W-1:0]              den,
   output logic                          done,
   output logic [fma_pkg::SCALE_W-1:0]   quot,
   output logic [DEN_W-1:0]              rem
);

   import fma_pkg::*;

   localparam int CNT_W = $clog2(SCALE_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SCALE_W-1:0]  low_ff, low_in;
   logic [SCALE_W-1:0]  quot_ff, quot_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;

   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      trial_sub;
   logic                ge;

   // one restoring step: shift in the next numerator bit, compare, subtract
   assign trial     = {rem_ff, low_ff[SCALE_W-1]};
   assign ge        = trial >= {1'b0, den};
   assign trial_sub = trial - {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         low_in  = num[SCALE_W-1:0];
         quot_in = '0;
         rem_in  = DEN_W'(num[NUM_W-1:SCALE_W]);
      end else if (busy_ff) begin
         low_in  = {low_ff[SCALE_W-2:0], 1'b0};
         quot_in = {quot_ff[SCALE_W-2:0], ge};
         rem_in  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SCALE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

/* tb/frame_minmax_autoscale_tb.sv */
`timescale 1ns / 1ps

module frame_minmax_autoscale_tb;
   import fma_pkg::*;

   localparam int          STORE_DEPTH = DEF_MAX_PIXELS;
   localparam int          RAND_ITEMS  = 800;
   localparam int          SETTLE      = 24;
   localparam int          DRILL_N     = 14;
   localparam int unsigned RAW_TOP     = 65535;

   typedef struct packed {
      logic [SCALE_W-1:0] scaled;
      logic               frame_end;
   } stretch_type;

   typedef struct {
      fma_op_type     op;
      logic [RAW_W-1:0] pixel;
      logic           first;
      bit             typed;
      stretch_type    res;
   } drill_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_op;
   logic [RAW_W-1:0]      req_pixel;
   logic                  req_first;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SCALE_W-1:0]    rsp_scaled;
   logic                  rsp_frame_end;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the block state
   logic [RAW_W-1:0] pix_store [STORE_DEPTH];
   bit               pix_written [STORE_DEPTH];
   int unsigned      frame_cfg;
   int unsigned      lo_seen;
   int unsigned      hi_seen;
   int unsigned      wr_pos;
   int unsigned      rd_pos;

   stretch_type scaled_due [$];
   int unsigned mismatches;
   int unsigned sent_items;
   bit          no_gaps;
   int unsigned band_lo;
   int unsigned band_w;

   drill_row_type drill_rows [DRILL_N] = '{
      '{OP_LOAD, 16'd0,      1'b1, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd65535,  1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd32768,  1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd1,      1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd40000,  1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd10,     1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_EMIT, 16'h0000,   1'b0, 1'b1, '{8'd0,   1'b0}},
      '{OP_EMIT, 16'hFFFF,   1'b0, 1'b1, '{8'd255, 1'b0}},
      '{OP_EMIT, 16'h5A5A,   1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_EMIT, 16'hA5A5,   1'b1, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd1000,   1'b1, 1'b0, '{8'd0,   1'b0}},
      '{OP_LOAD, 16'd2000,   1'b0, 1'b0, '{8'd0,   1'b0}},
      '{OP_EMIT, 16'h1234,   1'b0, 1'b1, '{8'd255, 1'b0}},
      '{OP_EMIT, 16'hFFFF,   1'b0, 1'b1, '{8'd0,   1'b0}}
   };

   int unsigned size_plan [8] = '{131072, 3, 0, 32'h3FFFF, 1, 5, 2, 12};

   frame_minmax_autoscale dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_pixel     (req_pixel),
      .req_first     (req_first),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scaled    (rsp_scaled),
      .rsp_frame_end (rsp_frame_end),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned active_size();
      if (frame_cfg == 0) return 1;
      if (frame_cfg > STORE_DEPTH) return STORE_DEPTH;
      return frame_cfg;
   endfunction

   function automatic int unsigned next_pos(int unsigned p);
      return (p + 1 >= active_size()) ? 0 : p + 1;
   endfunction

   function automatic logic [SCALE_W-1:0] stretch_pixel(logic [RAW_W-1:0] p);
      int unsigned span;
      int unsigned num;
      int unsigned q;
      int unsigned r;
      if (hi_seen < lo_seen || p < lo_seen) return '0;
      span = hi_seen - lo_seen + 1;
      num  = (p - lo_seen) * 255;
      q    = num / span;
      r    = num % span;
      if (2 * r > span || (2 * r == span && q[0])) q++;
      return (q > 255) ? SCALE_MAX : q[SCALE_W-1:0];
   endfunction

   task automatic track_item(input fma_op_type op, input logic [RAW_W-1:0] pix,
                             input logic first, output bit emits, output stretch_type res);
      res   = '0;
      emits = 1'b0;
      if (op == OP_LOAD) begin
         if (first) begin
            lo_seen = RAW_TOP;
            hi_seen = 0;
            wr_pos  = 0;
         end
         pix_store[wr_pos]   = pix;
         pix_written[wr_pos] = 1'b1;
         if (pix < lo_seen) lo_seen = 32'(pix);
         if (pix > hi_seen) hi_seen = 32'(pix);
         wr_pos = next_pos(wr_pos);
      end else begin
         res.frame_end = (rd_pos + 1 >= active_size());
         res.scaled    = stretch_pixel(pix_store[rd_pos]);
         rd_pos        = next_pos(rd_pos);
         emits         = 1'b1;
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [RAW_W-1:0] pick_pixel();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return RAW_W'($urandom);
      return RAW_W'(band_lo + $urandom_range(0, band_w));
   endfunction

   task automatic pick_band();
      int unsigned widths [7] = '{0, 1, 2, 3, 15, 255, 4095};
      band_w  = widths[$urandom_range(0, 6)];
      band_lo = $urandom_range(0, RAW_TOP - band_w);
   endtask

   // called at a rising edge; returns at the edge the transaction was taken, or after the gap
   task automatic send_item(input fma_op_type op, input logic [RAW_W-1:0] pix,
                            input logic first, input bit typed = 1'b0,
                            input stretch_type typed_res = '0);
      bit          emits;
      stretch_type res;
      int unsigned gap;
      req_valid <= 1'b1;
      req_op    <= op;
      req_pixel <= pix;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      track_item(op, pix, first, emits, res);
      if (emits) scaled_due = {scaled_due, (typed ? typed_res : res)};
      sent_items++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // an emit only ever reads an entry that some load has written
   task automatic emit_next();
      while (!pix_written[rd_pos]) send_item(OP_LOAD, pick_pixel(), 1'b0);
      send_item(OP_EMIT, RAW_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic drain(input int unsigned settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (scaled_due.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= ADDR_FRAME_PIXELS;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_frame_reg(input int unsigned want);
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, '0, got);
      if (got !== CSR_DATA_W'(want)) begin
         mismatches++;
         $display("%0t frame_pixels readback expected %0d got %0d", $time, want, got);
      end
   endtask

   task automatic set_frame_size(input int unsigned value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, CSR_DATA_W'(value), unused);
      frame_cfg = value;
      check_frame_reg(value);
   endtask

   task automatic run_frame();
      int unsigned n;
      n = (active_size() <= 16) ? active_size() : $urandom_range(1, 12);
      pick_band();
      send_item(OP_LOAD, pick_pixel(), 1'b1);
      repeat (n - 1) send_item(OP_LOAD, pick_pixel(), 1'b0);
      repeat (n) emit_next();
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 1)) emit_next();
         else send_item(OP_LOAD, RAW_W'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      int unsigned r;
      int unsigned len;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(50, 200);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 6);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            len = $urandom_range(10, 40);
         end
         repeat (len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      stretch_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scaled_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected transaction scaled=%0d frame_end=%0b",
                     $time, rsp_scaled, rsp_frame_end);
         end else begin
            want = scaled_due.pop_front();
            if (rsp_scaled !== want.scaled) begin
               mismatches++;
               $display("%0t scaled expected %0d got %0d", $time, want.scaled, rsp_scaled);
            end
            if (rsp_frame_end !== want.frame_end) begin
               mismatches++;
               $display("%0t frame_end expected %0b got %0b",
                        $time, want.frame_end, rsp_frame_end);
            end
         end
      end
   end

   initial begin
      int unsigned phase;
      int unsigned target;
      int unsigned rand_base;
      int unsigned size;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_op      = OP_LOAD;
      req_pixel   = '0;
      req_first   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatches  = 0;
      sent_items  = 0;
      no_gaps     = 1'b0;
      frame_cfg   = FRAME_RESET;
      lo_seen     = RAW_TOP;
      hi_seen     = 0;
      wr_pos      = 0;
      rd_pos      = 0;
      band_lo     = 0;
      band_w      = 3;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_frame_reg(FRAME_RESET);

      for (int i = 0; i < DRILL_N; i++)
         send_item(drill_rows[i].op, drill_rows[i].pixel, drill_rows[i].first,
                   drill_rows[i].typed, drill_rows[i].res);

      rand_base = sent_items;
      phase     = 0;
      while (sent_items - rand_base < RAND_ITEMS) begin
         r_size: begin
            r_pick: size = (phase < 8) ? size_plan[phase] :
                           ($urandom_range(0, 9) == 0) ? 0 :
                           ($urandom_range(0, 8) == 0) ? $urandom_range(13, 300) :
                           $urandom_range(1, 12);
         end
         // read position must hold a written entry before the frame size moves
         while (!pix_written[rd_pos]) send_item(OP_LOAD, pick_pixel(), 1'b0);
         drain(SETTLE);
         set_frame_size(size);
         no_gaps = ($urandom_range(0, 3) == 0);
         target  = sent_items + $urandom_range(40, 80);
         while (sent_items < target) begin
            if ($urandom_range(0, 19) == 0) drain(0);
            if ($urandom_range(0, 4) != 0) run_frame();
            else run_noise();
         end
         phase++;
      end

      drain(SETTLE);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
